### hw/rtl/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg: shared types and constants of the axis homing sequencer
// Phase codes, DAC word layout, flag and result word structs.
// ----------------------------------------------------------------------------
package ahs_pkg;

  // Phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEFT   = 3'd1;
  localparam logic [2:0] PH_PAUSEL = 3'd2;
  localparam logic [2:0] PH_RIGHT  = 3'd3;
  localparam logic [2:0] PH_PAUSER = 3'd4;
  localparam logic [2:0] PH_CENTER = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  // DAC word: 8-bit channel-0 prefix, 12-bit code, 4 zero bits
  localparam logic [7:0]         DAC_PREFIX   = 8'h18;
  localparam logic signed [12:0] DAC_MID_CODE = 13'sd2048;
  localparam logic signed [12:0] DAC_MAX_CODE = 13'sd4095;

  localparam int            DRIVE_W     = 11;
  localparam logic [10:0]   DRIVE_RESET = 11'd120;

  // Register map
  localparam logic REG_HOMING_DRIVE = 1'b0;

  typedef struct packed {
    logic wr;
    logic clr;
    logic lat;
    logic done;
    logic fault;
  } ahs_flags_t;

  // Result word, lowest field in the lowest bits (32 bits total)
  typedef struct packed {
    logic        amp_fault;
    logic [2:0]  phase;
    logic        homing_done;
    logic        latch_counters;
    logic        clear_counters;
    logic [23:0] dac_command;
    logic        dac_write;
  } ahs_result_t;

endpackage

### hw/rtl/axis_homing_sequencer_unit.sv
// ----------------------------------------------------------------------------
// axis_homing_sequencer_unit: linear axis homing to limit switches
// Input register, one-step homing logic, result register, APB config.
// ----------------------------------------------------------------------------
// One input word per timer tick (tuser = 1 for a start request). Each word
// gives exactly one result word. The block takes a word every cycle unless
// the output side stalls: a word is held in the input register, the homing
// step is computed in one pass of combinational logic and the result lands
// in the output register, so throughput is one word per cycle, limited only
// by the output side taking results. The sequence runs: idle, move
// left to the left switch, pause (counters cleared), move right while
// recording the right end, pause (midpoint = right end / 2 toward zero),
// move back until below the midpoint, done. Drive words are 0x18 prefix,
// 12-bit code 2048 +/- homing_drive, four zero bits. homing_drive lives at
// byte address 0 of the config port and must only be written while idle.
// ----------------------------------------------------------------------------
module axis_homing_sequencer_unit #(
  parameter int COUNT_BITS = 20
) (
  input  logic clk,
  input  logic rst_n,
  // tdata: amp_ok [0], left_limit [1], right_limit [2],
  //        encoder_count [COUNT_BITS+2:3], zero pad above
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((3+COUNT_BITS+7)/8)*8-1:0]        in_tdata,
  // tuser: cmd [0] (0 tick, 1 start)
  input  logic                                     in_tuser,
  // tdata: dac_write [0], dac_command [24:1], clear_counters [25],
  //        latch_counters [26], homing_done [27], phase [30:28], amp_fault [31]
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [31:0]                              out_tdata,
  // config
  input  logic                                     cfg_psel,
  input  logic                                     cfg_penable,
  input  logic                                     cfg_pwrite,
  input  logic [2:0]                               cfg_paddr,
  input  logic [31:0]                              cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int IN_W = ((3 + COUNT_BITS + 7) / 8) * 8;

  // input register
  logic                       in_v_r;
  logic                       in_cmd_r;
  logic [IN_W-1:0]            in_data_r;

  // sequencer state
  logic [2:0]                   phase_r,     phase_nxt;
  logic                         armed_r,     armed_nxt;
  logic signed [COUNT_BITS-1:0] right_end_r, right_end_nxt;
  logic signed [COUNT_BITS-1:0] mid_point_r, mid_point_nxt;

  // result register
  logic                       out_v_r;
  ahs_pkg::ahs_result_t       res_r;
  ahs_pkg::ahs_result_t       res_nxt;

  logic [ahs_pkg::DRIVE_W-1:0] homing_drive;
  logic                        advance;
  logic                        in_acc;

  // The step fires when a word is waiting and the output register is free or being emptied
  assign advance   = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | advance;
  assign in_acc    = in_tvalid & in_tready;

  ahs_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .homing_drive (homing_drive)
  );

  ahs_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cmd           (in_cmd_r),
    .amp_ok        (in_data_r[0]),
    .left_sw       (in_data_r[1]),
    .right_sw      (in_data_r[2]),
    .pos           ($signed(in_data_r[3 +: COUNT_BITS])),
    .homing_drive  (homing_drive),
    .phase         (phase_r),
    .armed         (armed_r),
    .right_end     (right_end_r),
    .mid_point     (mid_point_r),
    .phase_nxt     (phase_nxt),
    .armed_nxt     (armed_nxt),
    .right_end_nxt (right_end_nxt),
    .mid_point_nxt (mid_point_nxt),
    .result        (res_nxt)
  );

  // valid bits and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      phase_r     <= ahs_pkg::PH_IDLE;
      armed_r     <= 1'b0;
      right_end_r <= '0;
      mid_point_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r     <= 1'b1;
        phase_r     <= phase_nxt;
        armed_r     <= armed_nxt;
        right_end_r <= right_end_nxt;
        mid_point_r <= mid_point_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cmd_r  <= in_tuser;
      in_data_r <= in_tdata;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = res_r;

  // A running sequence always belongs to an armed block
  a_phase_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != ahs_pkg::PH_IDLE) |-> armed_r)
    else $error("phase active while not armed");

  // Completion leaves the block idle and disarmed
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.homing_done) |=>
      (phase_r == ahs_pkg::PH_IDLE) && !armed_r && out_tvalid)
    else $error("done without return to idle");

  // No DAC word without a write strobe
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res_r.dac_write) |-> (res_r.dac_command == 24'd0))
    else $error("dac command without write");

  // Full stage with a stalled output must hold off new words
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline stalled");

endmodule

### hw/rtl/ahs_regs.sv
// ----------------------------------------------------------------------------
// ahs_regs: configuration register file
// APB-style slave holding the homing drive magnitude.
// ----------------------------------------------------------------------------
module ahs_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [ahs_pkg::DRIVE_W-1:0] homing_drive
);

  logic [ahs_pkg::DRIVE_W-1:0] drive_r;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == ahs_pkg::REG_HOMING_DRIVE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= ahs_pkg::DRIVE_RESET;
    end else if (wr_en) begin
      drive_r <= pwdata[ahs_pkg::DRIVE_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == ahs_pkg::REG_HOMING_DRIVE) begin
      prdata = {{(32-ahs_pkg::DRIVE_W){1'b0}}, drive_r};
    end
  end

  assign homing_drive = drive_r;

endmodule

### hw/rtl/ahs_step.sv
// ----------------------------------------------------------------------------
// ahs_step: one homing step
// Next phase, recorded positions and result word for one input word.
// ----------------------------------------------------------------------------
module ahs_step #(
  parameter int COUNT_BITS = 20
) (
  input  logic                          cmd,
  input  logic                          amp_ok,
  input  logic                          left_sw,
  input  logic                          right_sw,
  input  logic signed [COUNT_BITS-1:0]  pos,
  input  logic [ahs_pkg::DRIVE_W-1:0]   homing_drive,
  input  logic [2:0]                    phase,
  input  logic                          armed,
  input  logic signed [COUNT_BITS-1:0]  right_end,
  input  logic signed [COUNT_BITS-1:0]  mid_point,
  output logic [2:0]                    phase_nxt,
  output logic                          armed_nxt,
  output logic signed [COUNT_BITS-1:0]  right_end_nxt,
  output logic signed [COUNT_BITS-1:0]  mid_point_nxt,
  output ahs_pkg::ahs_result_t          result
);

  logic signed [12:0]           drv_pos;
  logic signed [12:0]           drive;
  logic signed [12:0]           code_s;
  logic [11:0]                  code;
  logic signed [COUNT_BITS-1:0] re_bias;
  logic signed [COUNT_BITS-1:0] re_half;
  ahs_pkg::ahs_flags_t          fl;

  assign drv_pos = $signed({2'b00, homing_drive});

  // Halve toward zero: add one before the arithmetic shift when negative
  assign re_bias = right_end + $signed({{(COUNT_BITS-1){1'b0}}, right_end[COUNT_BITS-1]});
  assign re_half = re_bias >>> 1;

  always_comb begin
    phase_nxt     = phase;
    armed_nxt     = armed;
    right_end_nxt = right_end;
    mid_point_nxt = mid_point;
    fl            = '0;
    drive         = '0;
    if (cmd) begin
      armed_nxt = 1'b1;
    end else if (armed) begin
      unique case (phase)
        ahs_pkg::PH_IDLE: begin
          right_end_nxt = '0;
          mid_point_nxt = '0;
          if (amp_ok) begin
            phase_nxt = left_sw ? ahs_pkg::PH_PAUSEL : ahs_pkg::PH_LEFT;
          end
        end
        ahs_pkg::PH_LEFT: begin
          fl.wr  = 1'b1;
          fl.clr = 1'b1;
          fl.lat = 1'b1;
          drive  = -drv_pos;
          if (left_sw) begin
            drive     = '0;
            phase_nxt = ahs_pkg::PH_PAUSEL;
          end
        end
        ahs_pkg::PH_PAUSEL: begin
          fl.clr    = 1'b1;
          fl.lat    = 1'b1;
          phase_nxt = ahs_pkg::PH_RIGHT;
        end
        ahs_pkg::PH_RIGHT: begin
          fl.wr         = 1'b1;
          fl.lat        = 1'b1;
          drive         = drv_pos;
          right_end_nxt = pos;
          if (right_sw) begin
            drive     = '0;
            phase_nxt = ahs_pkg::PH_PAUSER;
          end
        end
        ahs_pkg::PH_PAUSER: begin
          fl.lat        = 1'b1;
          mid_point_nxt = re_half;
          phase_nxt     = ahs_pkg::PH_CENTER;
        end
        ahs_pkg::PH_CENTER: begin
          fl.wr  = 1'b1;
          fl.lat = 1'b1;
          drive  = -drv_pos;
          if (pos < mid_point) begin
            phase_nxt = ahs_pkg::PH_DONE;
          end
        end
        ahs_pkg::PH_DONE: begin
          fl.wr         = 1'b1;
          fl.clr        = 1'b1;
          fl.done       = 1'b1;
          right_end_nxt = '0;
          mid_point_nxt = '0;
          armed_nxt     = 1'b0;
          phase_nxt     = ahs_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = ahs_pkg::PH_IDLE;
        end
      endcase
    end
    fl.fault = armed_nxt & ~amp_ok;
  end

  // Offset and saturate the drive into a 12-bit code
  assign code_s = ahs_pkg::DAC_MID_CODE + drive;
  always_comb begin
    if (code_s < 13'sd0) begin
      code = '0;
    end else if (code_s > ahs_pkg::DAC_MAX_CODE) begin
      code = ahs_pkg::DAC_MAX_CODE[11:0];
    end else begin
      code = code_s[11:0];
    end
  end

  always_comb begin
    result                = '0;
    result.dac_write      = fl.wr;
    result.dac_command    = fl.wr ? {ahs_pkg::DAC_PREFIX, code, 4'h0} : 24'd0;
    result.clear_counters = fl.clr;
    result.latch_counters = fl.lat;
    result.homing_done    = fl.done;
    result.phase          = phase_nxt;
    result.amp_fault      = fl.fault;
  end

endmodule

### test/axis_homing_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// axis_homing_sequencer_unit_tb: self-checking bench for the homing sequencer
// Drives timer ticks and start requests, predicts every result word from its
// own model of the homing phases, and checks each word field by field. The
// stimulus follows the cart through whole homing runs, mixed with noise.
// ----------------------------------------------------------------------------
module axis_homing_sequencer_unit_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RUN_PHASES     = 5;
  localparam int TICKS_PER_RUN  = 226;

  // One input word as the sender sees it
  typedef struct packed {
    logic               cmd;
    logic               amp_ok;
    logic               left_sw;
    logic               right_sw;
    logic signed [19:0] enc;
  } homing_tick_t;

  // --------------------------------------------------------------------------
  // Homing tracker: own copy of the phase machine and the drive setting, plus
  // the queue of result words still to come out of the block.
  // --------------------------------------------------------------------------
  class homing_tracker;
    logic [10:0]          drive_mag;
    logic [2:0]           phase;
    bit                   armed;
    logic signed [19:0]   right_end;
    logic signed [19:0]   mid_point;
    ahs_pkg::ahs_result_t expected_words[$];
    int                   errors;
    int                   words_checked;
    int                   runs_done;
    int                   faults_seen;

    function new();
      drive_mag = ahs_pkg::DRIVE_RESET;
      phase     = ahs_pkg::PH_IDLE;
      armed     = 0;
      right_end = '0;
      mid_point = '0;
      errors    = 0;
      words_checked = 0;
      runs_done = 0;
      faults_seen = 0;
    endfunction

    // channel-0 DAC word for a signed drive value, code saturated to 12 bits
    function logic [23:0] dac_word(int d);
      int code;
      code = int'(ahs_pkg::DAC_MID_CODE) + d;
      if (code > int'(ahs_pkg::DAC_MAX_CODE)) code = int'(ahs_pkg::DAC_MAX_CODE);
      else if (code < 0) code = 0;
      return {ahs_pkg::DAC_PREFIX, code[11:0], 4'h0};
    endfunction

    // Advance the phase machine on an accepted input word
    function void note_tick(homing_tick_t t);
      ahs_pkg::ahs_result_t r;
      int d;
      r = '0;
      d = 0;
      if (t.cmd) begin
        armed = 1;
      end else if (armed) begin
        case (phase)
          ahs_pkg::PH_IDLE: begin
            right_end = '0;
            mid_point = '0;
            if (t.amp_ok) phase = t.left_sw ? ahs_pkg::PH_PAUSEL : ahs_pkg::PH_LEFT;
          end
          ahs_pkg::PH_LEFT: begin
            r.dac_write = 1; r.clear_counters = 1; r.latch_counters = 1;
            d = -int'(drive_mag);
            if (t.left_sw) begin
              d = 0;
              phase = ahs_pkg::PH_PAUSEL;
            end
          end
          ahs_pkg::PH_PAUSEL: begin
            r.clear_counters = 1; r.latch_counters = 1;
            phase = ahs_pkg::PH_RIGHT;
          end
          ahs_pkg::PH_RIGHT: begin
            r.dac_write = 1; r.latch_counters = 1;
            d = int'(drive_mag);
            right_end = t.enc;
            if (t.right_sw) begin
              d = 0;
              phase = ahs_pkg::PH_PAUSER;
            end
          end
          ahs_pkg::PH_PAUSER: begin
            r.latch_counters = 1;
            mid_point = right_end / 2;   // signed, truncates toward zero
            phase = ahs_pkg::PH_CENTER;
          end
          ahs_pkg::PH_CENTER: begin
            r.dac_write = 1; r.latch_counters = 1;
            d = -int'(drive_mag);
            if (t.enc < mid_point) phase = ahs_pkg::PH_DONE;
          end
          ahs_pkg::PH_DONE: begin
            r.dac_write = 1; r.clear_counters = 1; r.homing_done = 1;
            d = 0;
            right_end = '0;
            mid_point = '0;
            armed = 0;
            phase = ahs_pkg::PH_IDLE;
          end
          default: phase = ahs_pkg::PH_IDLE;
        endcase
      end
      if (r.dac_write) r.dac_command = dac_word(d);
      r.phase     = phase;
      r.amp_fault = armed && !t.amp_ok;
      expected_words.push_back(r);
    endfunction

    function void field_diff(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t mismatch %s: expected 0x%0h actual 0x%0h", $time, name, e, a);
      end
    endfunction

    // Compare an accepted result word against the oldest expectation
    function void check_word(ahs_pkg::ahs_result_t got);
      ahs_pkg::ahs_result_t e;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none actual 0x%08h", $time, got);
        return;
      end
      e = expected_words.pop_front();
      words_checked++;
      if (e.homing_done) runs_done++;
      if (e.amp_fault) faults_seen++;
      field_diff("dac_write",      64'(e.dac_write),      64'(got.dac_write));
      field_diff("dac_command",    64'(e.dac_command),    64'(got.dac_command));
      field_diff("clear_counters", 64'(e.clear_counters), 64'(got.clear_counters));
      field_diff("latch_counters", 64'(e.latch_counters), 64'(got.latch_counters));
      field_diff("homing_done",    64'(e.homing_done),    64'(got.homing_done));
      field_diff("phase",          64'(e.phase),          64'(got.phase));
      field_diff("amp_fault",      64'(e.amp_fault),      64'(got.amp_fault));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;     // amp_ok [0], left_limit [1], right_limit [2],
                             // encoder_count [22:3], zero [23]
  logic        in_tuser;     // cmd [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // dac_write [0], dac_command [24:1], clear [25],
                             // latch [26], done [27], phase [30:28], fault [31]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  homing_tracker tracker;

  int cart_pos;        // where the stimulus believes the cart is
  int burst_left;      // words left in the current sender burst
  int ticks_sent;
  int quiet_cycles;
  int ready_cycle;
  int ready_mode;

  axis_homing_sequencer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: every accepted word goes to the tracker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_word(ahs_pkg::ahs_result_t'(out_tdata));
    end
  end

  // Receiver backpressure: the mode is re-picked at random between always
  // ready, coin-flip, and mostly stalled, so stalls hit every phase.
  always @(negedge clk) begin
    ready_cycle++;
    if (ready_cycle % 150 == 0) ready_mode = $urandom_range(0, 2);
    case (ready_mode)
      0:       out_tready = 1'b1;
      1:       out_tready = 1'($urandom_range(0, 1));
      default: out_tready = ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: any handshake or config access counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL axis_homing_sequencer_unit");
        $finish;
      end
    end
  end

  // Offer one word, wait for the handshake, then let the tracker see it.
  // Valid stays high across a burst; a gap between bursts lowers it.
  task automatic send_tick(homing_tick_t t);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = t.cmd;
    in_tdata  = {1'b0, t.enc, t.right_sw, t.left_sw, t.amp_ok};
    do @(posedge clk); while (!in_tready);
    tracker.note_tick(t);
    ticks_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic drive_tick(bit cmd, bit amp, bit lsw, bit rsw, int enc);
    homing_tick_t t;
    t.cmd = cmd; t.amp_ok = amp; t.left_sw = lsw; t.right_sw = rsw;
    t.enc = enc[19:0];
    send_tick(t);
  endtask

  // Drain the block, then write homing_drive and read it back
  task automatic set_drive(logic [10:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);   // margin before the config access
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = {ahs_pkg::REG_HOMING_DRIVE, 2'b00};
    cfg_pwdata = {21'd0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_pready) tracker.drive_mag = val;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_psel = 1'b1;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {21'd0, val}) begin
      tracker.errors++;
      $display("%0t mismatch homing_drive readback: expected 0x%0h actual 0x%0h",
               $time, {21'd0, val}, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0;
  endtask

  // Next stimulus word, shaped by the phase the tracker says the block is in.
  // Mostly clean homing runs with random content; the rest is noise.
  function automatic homing_tick_t next_tick();
    homing_tick_t t;
    int roll;
    logic [31:0] pos;
    roll = $urandom_range(0, 99);
    t.cmd      = 1'b0;
    t.amp_ok   = ($urandom_range(0, 19) != 0);
    t.left_sw  = ($urandom_range(0, 3) == 0);
    t.right_sw = ($urandom_range(0, 3) == 0);
    if (roll < 8) begin
      // noise: every field random
      t = homing_tick_t'(24'($urandom));
      return t;
    end
    if (!tracker.armed) begin
      t.cmd = ($urandom_range(0, 6) != 0);
    end else begin
      t.cmd = (roll < 11);   // restart request while running
      case (tracker.phase)
        ahs_pkg::PH_LEFT: begin
          cart_pos -= $urandom_range(1, 30000);
          t.left_sw = ($urandom_range(0, 4) == 0);
        end
        ahs_pkg::PH_PAUSEL: cart_pos = 0;   // counters cleared at the left end
        ahs_pkg::PH_RIGHT: begin
          cart_pos += ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300000)
                                                  : $urandom_range(1, 40000);
          t.right_sw = ($urandom_range(0, 5) == 0);
        end
        ahs_pkg::PH_CENTER: cart_pos -= $urandom_range(1, 60000);
        default: ;
      endcase
    end
    pos = cart_pos;
    t.enc = ($urandom_range(0, 9) == 0) ? 20'($urandom) : pos[19:0];
    return t;
  endfunction

  initial begin
    logic [10:0] drive_plan [RUN_PHASES];
    int useful;
    bit counts;
    homing_tick_t t;

    tracker     = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cart_pos    = 0;
    burst_left  = 4;
    ticks_sent  = 0;
    quiet_cycles = 0;
    ready_cycle = 0;
    ready_mode  = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part, reset drive setting ----
    drive_tick(0, 0, 1, 1, -524288);   // tick while not armed: ignored
    drive_tick(0, 1, 0, 0, 524287);
    drive_tick(1, 1, 0, 0, 0);         // start request arms
    drive_tick(0, 0, 0, 0, 0);         // amp fault holds the block idle
    drive_tick(0, 1, 1, 0, 0);         // already on left switch: skip move
    drive_tick(0, 1, 0, 0, 0);         // pause left
    drive_tick(0, 1, 0, 0, 524287);    // move right
    drive_tick(0, 1, 0, 1, -524287);   // right switch, odd negative end
    drive_tick(0, 1, 0, 0, 0);         // pause right: mid rounds toward zero
    drive_tick(1, 1, 0, 0, 0);         // start request mid-run changes nothing
    drive_tick(0, 1, 0, 0, -262143);   // equal to midpoint: keep moving
    drive_tick(0, 0, 0, 0, -524288);   // below midpoint, amp fault flagged
    drive_tick(0, 1, 0, 0, 0);         // done
    drive_tick(1, 1, 0, 0, 0);
    drive_tick(0, 1, 0, 0, 0);         // idle to move left
    drive_tick(0, 0, 0, 0, -5);        // moving left with amp fault
    drive_tick(0, 1, 1, 0, -9);        // left switch: stop word
    drive_tick(0, 1, 0, 0, 0);
    drive_tick(0, 1, 0, 0, 1000);
    drive_tick(0, 1, 0, 1, 1001);
    drive_tick(0, 1, 0, 0, 1001);
    drive_tick(0, 1, 0, 0, 500);
    drive_tick(0, 1, 0, 0, 499);
    drive_tick(0, 1, 0, 0, 499);
    drive_tick(0, 1, 1, 1, 7);         // back to idle, not armed

    // ---- random part over several drive settings, extremes included ----
    drive_plan[0] = 11'd0;
    drive_plan[1] = 11'd2047;
    drive_plan[2] = 11'd1;
    drive_plan[3] = 11'd1500;
    drive_plan[4] = 11'($urandom_range(2, 2046));
    for (int p = 0; p < RUN_PHASES; p++) begin
      set_drive(drive_plan[p]);
      useful = 0;
      while (useful < TICKS_PER_RUN) begin
        t = next_tick();
        counts = t.cmd || tracker.armed;   // unarmed ticks do nothing
        send_tick(t);
        if (counts) useful++;
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words, checked %0d results, %0d homing runs completed,",
             ticks_sent, tracker.words_checked, tracker.runs_done);
    $display("%0d amp-fault results, drive swept from reset value through 0 and 2047",
             tracker.faults_seen);
    if (tracker.errors == 0) begin
      $display("PASS axis_homing_sequencer_unit");
    end else begin
      $display("FAIL axis_homing_sequencer_unit");
    end
    $finish;
  end

endmodule
